### sv/aps_pkg.sv
// shared types, constants and saturation helpers for the allpass cascade phaser
package aps_pkg;

   localparam int SMP_W  = 24;
   localparam int WORD_W = 32;
   localparam int OPA_W  = 33;
   localparam int OPB_W  = 19;
   localparam int PROD_W = 52;

   // rounding addends for the q15 and mix shifts
   localparam logic signed [PROD_W-1:0] RND_Q15 = 52'sd16384;
   localparam logic signed [PROD_W-1:0] RND_MIX = 52'sd65536;
   // full weight of the mix, unity gain after the mix shift
   localparam logic [OPB_W-1:0] MIX_FULL = 19'd131072;

   typedef struct packed {
      logic signed [23:0] left_in;
      logic signed [23:0] right_in;
      logic signed [15:0] coefficient;
      logic signed [15:0] feedback_gain;
      logic [16:0]        wet_mix;
      logic               start_block;
   } aps_req_type;

   typedef struct packed {
      logic signed [23:0] left_out;
      logic signed [23:0] right_out;
      logic               clipped;
   } aps_rsp_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] prev_in;
      logic signed [WORD_W-1:0] prev_out;
   } aps_entry_type;

   typedef struct packed {
      logic clear;
      logic rd_en;
      logic wr_en;
   } aps_mem_ctl_type;

   typedef struct packed {
      logic                     clip;
      logic signed [WORD_W-1:0] val;
   } aps_sat_word_type;

   typedef struct packed {
      logic                    clip;
      logic signed [SMP_W-1:0] val;
   } aps_sat_smp_type;

   function automatic aps_sat_word_type sat_word(input logic signed [37:0] v);
      aps_sat_word_type r;
      if ((&v[37:31]) || !(|v[37:31])) begin
         r.clip = 1'b0;
         r.val  = v[31:0];
      end else begin
         r.clip = 1'b1;
         r.val  = v[37] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end
      return r;
   endfunction

   function automatic aps_sat_smp_type sat_smp(input logic signed [35:0] v);
      aps_sat_smp_type r;
      if ((&v[35:23]) || !(|v[35:23])) begin
         r.clip = 1'b0;
         r.val  = v[23:0];
      end else begin
         r.clip = 1'b1;
         r.val  = v[35] ? 24'sh80_0000 : 24'sh7f_ffff;
      end
      return r;
   endfunction

endpackage

### sv/aps_mul.sv
// shared signed multiply-add unit with registered product
module aps_mul import aps_pkg::*; (
   input  logic                     clock,
   input  logic                     en,
   input  logic signed [OPA_W-1:0]  a,
   input  logic signed [OPB_W-1:0]  b,
   input  logic signed [PROD_W-1:0] addend,
   output logic signed [PROD_W-1:0] p
);

   logic signed [PROD_W-1:0] p_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff <= a * b + addend;
      end
   end

   assign p = p_ff;

endmodule

### sv/aps_state_mem.sv
// stage history memory, one entry per channel and stage, with valid bits
module aps_state_mem import aps_pkg::*; #(
   parameter int AW = 4
) (
   input  logic            clock,
   input  logic            reset,
   input  aps_mem_ctl_type ctl,
   input  logic [AW-1:0]   rd_addr,
   input  logic [AW-1:0]   wr_addr,
   input  aps_entry_type   wr_data,
   output aps_entry_type   rd_data
);

   localparam int DEPTH = 2 ** AW;

   aps_entry_type    mem_ff [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   aps_entry_type    rd_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ctl.clear) begin
         valid_ff <= '0;
      end else if (ctl.wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= valid_ff[rd_addr] ? mem_ff[rd_addr] : '0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/allpass_cascade_phaser.sv
// top level of the allpass cascade phaser: sequencer and datapath around one multiplier
//
//   channel | direction | ports                          | word
//   req     | in        | req_valid req_ready req_data   | aps_req_type frame
//   rsp     | out       | rsp_valid rsp_ready rsp_data   | aps_rsp_type frame
//   csr     | in        | csr_valid csr_ready csr_data   | stereo enable bit
//
// one frame at a time; each channel runs through the shared multiplier stage by stage,
// each allpass stage being a multiply, then an add and saturate
// in stereo the right channel follows the left one on the same multiplier
// synchronous active-high reset clears the stereo bit, feedback and all stage history
// a result waiting on rsp_ready holds the last mix step; req_ready is high only when idle
module allpass_cascade_phaser import aps_pkg::*; #(
   parameter int STAGES = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  aps_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output aps_rsp_type rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data
);

   localparam int SW = (STAGES > 1) ? $clog2(STAGES) : 1;
   localparam int AW = SW + 1;
   localparam logic [SW-1:0] LAST_STAGE = SW'(STAGES - 1);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_FB_MUL = 3'd1;
   localparam logic [2:0] S_FB_ADD = 3'd2;
   localparam logic [2:0] S_ST_MUL = 3'd3;
   localparam logic [2:0] S_ST_ADD = 3'd4;
   localparam logic [2:0] S_MX_DRY = 3'd5;
   localparam logic [2:0] S_MX_WET = 3'd6;
   localparam logic [2:0] S_MX_ADD = 3'd7;

   logic [2:0]                state_ff, state_in;
   logic                      ch_ff, ch_in;
   logic [SW-1:0]             stage_ff, stage_in;
   aps_req_type               item_ff, item_in;
   logic                      stereo_ff;
   logic signed [WORD_W-1:0]  fb_left_ff, fb_left_in;
   logic signed [WORD_W-1:0]  fb_right_ff, fb_right_in;
   logic signed [WORD_W-1:0]  w_ff, w_in;
   logic signed [PROD_W-1:0]  acc_ff, acc_in;
   logic signed [SMP_W-1:0]   left_res_ff, left_res_in;
   logic                      clip_ff, clip_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   aps_rsp_type               rsp_data_ff, rsp_data_in;

   logic                      mul_en;
   logic signed [OPA_W-1:0]   mul_a;
   logic signed [OPB_W-1:0]   mul_b;
   logic signed [PROD_W-1:0]  mul_add;
   logic signed [PROD_W-1:0]  mul_p;

   aps_mem_ctl_type           mem_ctl;
   logic [AW-1:0]             mem_rd_addr;
   logic [AW-1:0]             mem_wr_addr;
   aps_entry_type             mem_wr_data;
   aps_entry_type             mem_rd_data;

   logic signed [SMP_W-1:0]   x_cur;
   logic signed [WORD_W-1:0]  fb_cur;
   logic signed [36:0]        p_q15;
   logic signed [37:0]        fb_sum;
   logic signed [37:0]        st_sum;
   logic signed [PROD_W:0]    mix_sum;
   logic signed [OPA_W-1:0]   diff;
   logic [SW-1:0]             stage_next;
   aps_sat_word_type          fb_sat;
   aps_sat_word_type          st_sat;
   aps_sat_smp_type           mix_sat;

   aps_mul u_mul (
      .clock  (clock),
      .en     (mul_en),
      .a      (mul_a),
      .b      (mul_b),
      .addend (mul_add),
      .p      (mul_p)
   );

   aps_state_mem #(.AW(AW)) u_mem (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mem_ctl),
      .rd_addr (mem_rd_addr),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_data (mem_rd_data)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign x_cur      = ch_ff ? item_ff.right_in : item_ff.left_in;
   assign fb_cur     = ch_ff ? fb_right_ff : fb_left_ff;
   assign p_q15      = mul_p[PROD_W-1:15];
   assign fb_sum     = {{14{x_cur[SMP_W-1]}}, x_cur} + {p_q15[36], p_q15};
   assign st_sum     = {{6{mem_rd_data.prev_in[WORD_W-1]}}, mem_rd_data.prev_in}
                       + {p_q15[36], p_q15};
   assign mix_sum    = {acc_ff[PROD_W-1], acc_ff} + {mul_p[PROD_W-1], mul_p};
   assign diff       = {mem_rd_data.prev_out[WORD_W-1], mem_rd_data.prev_out}
                       - {w_ff[WORD_W-1], w_ff};
   assign stage_next = stage_ff + 1'b1;
   assign fb_sat     = sat_word(fb_sum);
   assign st_sat     = sat_word(st_sum);
   assign mix_sat    = sat_smp(mix_sum[PROD_W:17]);

   always_comb begin
      state_in     = state_ff;
      ch_in        = ch_ff;
      stage_in     = stage_ff;
      item_in      = item_ff;
      fb_left_in   = fb_left_ff;
      fb_right_in  = fb_right_ff;
      w_in         = w_ff;
      acc_in       = acc_ff;
      left_res_in  = left_res_ff;
      clip_in      = clip_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      mul_en       = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      mul_add      = '0;
      mem_ctl      = '0;
      mem_rd_addr  = {ch_ff, stage_ff};
      mem_wr_addr  = {ch_ff, stage_ff};
      mem_wr_data.prev_in  = w_ff;
      mem_wr_data.prev_out = st_sat.val;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               item_in  = req_data;
               ch_in    = 1'b0;
               stage_in = '0;
               clip_in  = 1'b0;
               if (req_data.start_block) begin
                  mem_ctl.clear = 1'b1;
                  fb_left_in    = '0;
                  fb_right_in   = '0;
               end
               state_in = S_FB_MUL;
            end
         end
         S_FB_MUL: begin
            mul_en        = 1'b1;
            mul_a         = {fb_cur[WORD_W-1], fb_cur};
            mul_b         = {{3{item_ff.feedback_gain[15]}}, item_ff.feedback_gain};
            mul_add       = RND_Q15;
            mem_ctl.rd_en = 1'b1;
            state_in      = S_FB_ADD;
         end
         S_FB_ADD: begin
            w_in     = fb_sat.val;
            clip_in  = clip_ff | fb_sat.clip;
            state_in = S_ST_MUL;
         end
         S_ST_MUL: begin
            mul_en   = 1'b1;
            mul_a    = diff;
            mul_b    = {{3{item_ff.coefficient[15]}}, item_ff.coefficient};
            mul_add  = RND_Q15;
            state_in = S_ST_ADD;
         end
         S_ST_ADD: begin
            mem_ctl.wr_en = 1'b1;
            w_in          = st_sat.val;
            clip_in       = clip_ff | st_sat.clip;
            if (stage_ff == LAST_STAGE) begin
               stage_in = '0;
               if (ch_ff) begin
                  fb_right_in = st_sat.val;
               end else begin
                  fb_left_in = st_sat.val;
               end
               state_in = S_MX_DRY;
            end else begin
               stage_in      = stage_next;
               mem_ctl.rd_en = 1'b1;
               mem_rd_addr   = {ch_ff, stage_next};
               state_in      = S_ST_MUL;
            end
         end
         S_MX_DRY: begin
            mul_en   = 1'b1;
            mul_a    = {{9{x_cur[SMP_W-1]}}, x_cur};
            mul_b    = MIX_FULL - {2'b00, item_ff.wet_mix};
            mul_add  = RND_MIX;
            state_in = S_MX_WET;
         end
         S_MX_WET: begin
            acc_in   = mul_p;
            mul_en   = 1'b1;
            mul_a    = {w_ff[WORD_W-1], w_ff};
            mul_b    = {2'b00, item_ff.wet_mix};
            state_in = S_MX_ADD;
         end
         S_MX_ADD: begin
            if (!ch_ff && stereo_ff) begin
               left_res_in = mix_sat.val;
               clip_in     = clip_ff | mix_sat.clip;
               ch_in       = 1'b1;
               state_in    = S_FB_MUL;
            end else if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in        = 1'b1;
               rsp_data_in.clipped = clip_ff | mix_sat.clip;
               if (ch_ff) begin
                  rsp_data_in.left_out  = left_res_ff;
                  rsp_data_in.right_out = mix_sat.val;
               end else begin
                  rsp_data_in.left_out  = mix_sat.val;
                  rsp_data_in.right_out = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ch_ff        <= 1'b0;
         stage_ff     <= '0;
         stereo_ff    <= 1'b0;
         fb_left_ff   <= '0;
         fb_right_ff  <= '0;
         clip_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ch_ff        <= ch_in;
         stage_ff     <= stage_in;
         fb_left_ff   <= fb_left_in;
         fb_right_ff  <= fb_right_in;
         clip_ff      <= clip_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            stereo_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      w_ff        <= w_in;
      acc_ff      <= acc_in;
      left_res_ff <= left_res_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

### sv/aps_checker.sv
// port-level checker for the allpass cascade phaser and its bind
module aps_checker import aps_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input aps_rsp_type rsp_data
);

   // busy after taking a frame
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("req_ready high right after a frame was taken");

   // a frame never finishes in the cycle after it is taken
   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !$rose(rsp_valid))
      else $error("result appeared one cycle after accept");

   // a new result only comes out of a busy block
   a_result_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result appeared while the block was idle");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result word dropped or changed");

endmodule

bind allpass_cascade_phaser aps_checker u_aps_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
